// File: rtl/core/tcw_pkg.sv
// Package for the text console writer: payload structs, decoded command type,
// character and mode codes, and default screen geometry. No dependencies.
`default_nettype none
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;
  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_W     = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

  localparam logic [1:0] MODE_PRINT = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_BLANK     = 8'h00;
  localparam logic [7:0] ATTR_RESET   = 8'h0F;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  char_code;
    logic [10:0] cell_addr;
  } in_item_t;

  typedef struct packed {
    logic [15:0] cell_word;
    logic [10:0] cursor_pos;
    logic [4:0]  cursor_row;
  } out_item_t;

  typedef enum logic [2:0] {
    K_CHAR,
    K_NEWLINE,
    K_BACKSPACE,
    K_READ,
    K_CLEAR,
    K_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  ch;
    logic [10:0] addr;
    logic        addr_ok;
  } cmd_t;

endpackage
`default_nettype wire

// File: rtl/core/text_console_writer_top.sv
// Text console writer: valid/ready command in, valid/ready result out.
// Channels: in_data carries mode, char_code and cell_addr; out_data carries
// cell_word, cursor_pos and cursor_row; cfg_we/cfg_wdata set the attribute
// byte (reset value 0x0F), which is registered into the attribute register.
// One result per accepted item, in order. An item passes a two-entry queue
// and then the execution unit, whose screen memory (one write port, one
// registered read port) sets the timing: print, newline, backspace and
// unused modes finish in S_RUN, a read goes on through S_READ. Scroll walks
// the memory one cell a cycle, copying rows up, then blanking the last row;
// clear blanks every cell in turn. An item is registered in the queue and
// again in the result register. After reset all COLUMNS*ROWS cells are
// swept to 0x0F00 with in_ready low; configuration writes are still taken.
// When the receiver stalls, the result register holds, the queue fills,
// and in_ready drops once two commands are waiting.
// Depends on tcw_pkg, tcw_front, tcw_queue and tcw_back.
`default_nettype none
module text_console_writer_top #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  tcw_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output tcw_pkg::out_item_t out_data,
  input  wire logic          cfg_we,
  input  wire logic [7:0]    cfg_wdata
);
  import tcw_pkg::*;

  logic  init_busy;
  logic  q_push;
  logic  q_ready;
  cmd_t  push_cmd;
  logic  q_valid;
  logic  q_pop;
  cmd_t  pop_cmd;

  tcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .init_busy (init_busy),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  tcw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_ready (q_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_cmd    (pop_cmd)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_cmd     (pop_cmd),
    .q_pop     (q_pop),
    .init_busy (init_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// File: rtl/core/tcw_front.sv
// Front end: accepts input transfers and classifies them into commands.
// Depends on tcw_pkg.
`default_nettype none
module tcw_front #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  tcw_pkg::in_item_t     in_data,
  input  wire logic             init_busy,
  input  wire logic             q_ready,
  output logic                  q_push,
  output tcw_pkg::cmd_t         q_cmd
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;

  assign in_ready = q_ready && !init_busy;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    q_cmd.ch      = in_data.char_code;
    q_cmd.addr    = in_data.cell_addr;
    q_cmd.addr_ok = (32'(in_data.cell_addr) < 32'(CELLS));
    case (in_data.mode)
      MODE_PRINT: begin
        if (in_data.char_code == CH_NEWLINE) begin
          q_cmd.kind = K_NEWLINE;
        end else if (in_data.char_code == CH_BACKSPACE) begin
          q_cmd.kind = K_BACKSPACE;
        end else begin
          q_cmd.kind = K_CHAR;
        end
      end
      MODE_READ:  q_cmd.kind = K_READ;
      MODE_CLEAR: q_cmd.kind = K_CLEAR;
      default:    q_cmd.kind = K_NOP;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/core/tcw_queue.sv
// Short command queue between the front end and the back end.
// Depends on tcw_pkg.
`default_nettype none
module tcw_queue (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  output logic           push_ready,
  input  tcw_pkg::cmd_t  push_cmd,
  output logic           pop_valid,
  input  wire logic      pop,
  output tcw_pkg::cmd_t  pop_cmd
);
  import tcw_pkg::*;

  cmd_t                entry_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]  count_r, count_nxt;

  assign push_ready = (count_r != Q_CNT_W'(Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/tcw_back.sv
// Back end: screen memory, cursor, attribute register, scroll/clear sequencer
// and the result register. Depends on tcw_pkg.
`default_nettype none
module tcw_back #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [7:0]    cfg_wdata,
  input  wire logic          q_valid,
  input  tcw_pkg::cmd_t      q_cmd,
  output logic               q_pop,
  output logic               init_busy,
  output logic               out_valid,
  input  wire logic          out_ready,
  output tcw_pkg::out_item_t out_data
);
  import tcw_pkg::*;

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int POS_W  = $clog2(CELLS + 1);
  localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;

  typedef enum logic [2:0] {S_INIT, S_RUN, S_READ, S_COPY, S_FILL} state_t;

  state_t              state_r, state_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [7:0]          attr_r, attr_nxt;
  logic [POS_W-1:0]    src_r, src_nxt;
  logic [ADDR_W-1:0]   cp_dst_r, cp_dst_nxt;
  logic                cp_vld_r, cp_vld_nxt;
  logic [ADDR_W-1:0]   fill_r, fill_nxt;
  logic [15:0]         fill_word_r, fill_word_nxt;
  logic                rd_ok_r, rd_ok_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;

  logic [15:0]         screen_mem [CELLS];
  logic [15:0]         rd_data_r;
  logic [ADDR_W-1:0]   rd_addr;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [15:0]         mem_wdata;

  logic                slot_free;
  logic                emit;
  logic [15:0]         word;
  logic [POS_W-1:0]    bs_pos;
  logic [POS_W-1:0]    cp_diff;
  logic [ADDR_W+10:0]  addr_ext;
  logic [POS_W+10:0]   pos_ext;
  logic [ROW_W+4:0]    row_ext;

  assign slot_free = !out_valid_r || out_ready;
  assign init_busy = (state_r == S_INIT);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign addr_ext  = {{ADDR_W{1'b0}}, q_cmd.addr};
  assign bs_pos    = (pos_r == '0) ? '0 : pos_r - 1'b1;
  assign cp_diff   = src_r - POS_W'(COLUMNS);

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    attr_nxt      = cfg_we ? cfg_wdata : attr_r;
    src_nxt       = src_r;
    cp_dst_nxt    = cp_dst_r;
    cp_vld_nxt    = cp_vld_r;
    fill_nxt      = fill_r;
    fill_word_nxt = fill_word_r;
    rd_ok_nxt     = rd_ok_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = pos_r[ADDR_W-1:0];
    mem_wdata     = {attr_r, q_cmd.ch};
    rd_addr       = addr_ext[ADDR_W-1:0];
    emit          = 1'b0;
    word          = 16'd0;

    case (state_r)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = fill_r;
        mem_wdata = fill_word_r;
        if (fill_r == ADDR_W'(CELLS - 1)) begin
          state_nxt = S_RUN;
        end else begin
          fill_nxt = fill_r + 1'b1;
        end
      end
      S_RUN: begin
        if (q_valid && slot_free) begin
          q_pop = 1'b1;
          case (q_cmd.kind)
            K_CHAR: begin
              mem_we = 1'b1;
              if (pos_r == POS_W'(CELLS - 1)) begin
                src_nxt    = POS_W'(COLUMNS);
                cp_vld_nxt = 1'b0;
                pos_nxt    = POS_W'(CELLS - COLUMNS);
                row_nxt    = ROW_W'(ROWS - 1);
                col_nxt    = '0;
                state_nxt  = S_COPY;
              end else begin
                pos_nxt = pos_r + 1'b1;
                if (col_r == COL_W'(COLUMNS - 1)) begin
                  col_nxt = '0;
                  row_nxt = row_r + 1'b1;
                end else begin
                  col_nxt = col_r + 1'b1;
                end
                emit = 1'b1;
              end
            end
            K_NEWLINE: begin
              if (row_r == ROW_W'(ROWS - 1)) begin
                src_nxt    = POS_W'(COLUMNS);
                cp_vld_nxt = 1'b0;
                pos_nxt    = POS_W'(CELLS - COLUMNS);
                col_nxt    = '0;
                state_nxt  = S_COPY;
              end else begin
                pos_nxt = pos_r - POS_W'(col_r) + POS_W'(COLUMNS);
                col_nxt = '0;
                row_nxt = row_r + 1'b1;
                emit    = 1'b1;
              end
            end
            K_BACKSPACE: begin
              mem_we    = 1'b1;
              mem_waddr = bs_pos[ADDR_W-1:0];
              mem_wdata = {attr_r, CH_SPACE};
              pos_nxt   = bs_pos;
              if (pos_r != '0) begin
                if (col_r == '0) begin
                  col_nxt = COL_W'(COLUMNS - 1);
                  row_nxt = row_r - 1'b1;
                end else begin
                  col_nxt = col_r - 1'b1;
                end
              end
              emit = 1'b1;
            end
            K_READ: begin
              rd_ok_nxt = q_cmd.addr_ok;
              state_nxt = S_READ;
            end
            K_CLEAR: begin
              fill_nxt      = '0;
              fill_word_nxt = {attr_r, CH_BLANK};
              pos_nxt       = '0;
              row_nxt       = '0;
              col_nxt       = '0;
              state_nxt     = S_FILL;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        word      = rd_ok_r ? rd_data_r : 16'd0;
        emit      = 1'b1;
        state_nxt = S_RUN;
      end
      S_COPY: begin
        rd_addr = src_r[ADDR_W-1:0];
        if (cp_vld_r) begin
          mem_we    = 1'b1;
          mem_waddr = cp_dst_r;
          mem_wdata = rd_data_r;
        end
        if (src_r != POS_W'(CELLS)) begin
          src_nxt    = src_r + 1'b1;
          cp_vld_nxt = 1'b1;
          cp_dst_nxt = cp_diff[ADDR_W-1:0];
        end else begin
          cp_vld_nxt    = 1'b0;
          fill_nxt      = ADDR_W'(CELLS - COLUMNS);
          fill_word_nxt = {attr_r, CH_BLANK};
          state_nxt     = S_FILL;
        end
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = fill_r;
        mem_wdata = fill_word_r;
        if (fill_r == ADDR_W'(CELLS - 1)) begin
          emit      = 1'b1;
          state_nxt = S_RUN;
        end else begin
          fill_nxt = fill_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_RUN;
      end
    endcase

    pos_ext = {{11{1'b0}}, pos_nxt};
    row_ext = {{5{1'b0}}, row_nxt};
    if (emit) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.cell_word  = word;
      out_data_nxt.cursor_pos = pos_ext[10:0];
      out_data_nxt.cursor_row = row_ext[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      pos_r       <= '0;
      row_r       <= '0;
      col_r       <= '0;
      attr_r      <= ATTR_RESET;
      cp_vld_r    <= 1'b0;
      fill_r      <= '0;
      fill_word_r <= {ATTR_RESET, CH_BLANK};
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      attr_r      <= attr_nxt;
      cp_vld_r    <= cp_vld_nxt;
      fill_r      <= fill_nxt;
      fill_word_r <= fill_word_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r      <= src_nxt;
    cp_dst_r   <= cp_dst_nxt;
    rd_ok_r    <= rd_ok_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      screen_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= screen_mem[rd_addr];
  end

  a_cursor_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(row_r) * 32'(COLUMNS) + 32'(col_r)) == 32'(pos_r))
    else $error("cursor row/column disagree with position");

  a_copy_only_in_scroll: assert property (@(posedge clk) disable iff (!rst_n)
    cp_vld_r |-> (state_r == S_COPY))
    else $error("pending copy write outside scroll");

  a_pop_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (slot_free && state_r == S_RUN))
    else $error("command taken without a free result slot");

  a_no_pop_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INIT) |=> !q_pop)
    else $error("command taken during the clearing pass");

endmodule
`default_nettype wire

// File: tb/text_console_writer_top_tb.sv
// Testbench for text_console_writer_top: random and directed console commands
// checked against a screen-store predictor. Depends on tcw_pkg and the RTL.
`default_nettype none
module text_console_writer_top_tb;
  import tcw_pkg::*;

  localparam int COLS = COLUMNS_DEF;
  localparam int LINES = ROWS_DEF;
  localparam int CELLS = COLS * LINES;
  localparam logic [1:0] MODE_IDLE = 2'd3;
  localparam logic [7:0] CH_LETTER = 8'h41;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SESSION_ITEMS = 275;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;

  in_item_t command_backlog[$];
  out_item_t expected_reports[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_count = 0;

  logic [15:0] screen_cells[CELLS];
  int unsigned cursor_at;
  int unsigned cursor_line;
  logic [7:0] text_attr;

  always #2 clk = ~clk;

  text_console_writer_top DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  function automatic logic [15:0] cell_of(logic [7:0] ch);
    return {text_attr, ch};
  endfunction

  function automatic void blank_screen(logic [15:0] word);
    for (int i = 0; i < CELLS; i++) screen_cells[i] = word;
  endfunction

  function automatic void scroll_screen();
    for (int i = COLS; i < CELLS; i++) screen_cells[i - COLS] = screen_cells[i];
    for (int i = CELLS - COLS; i < CELLS; i++) screen_cells[i] = cell_of(CH_BLANK);
    cursor_at = CELLS - COLS;
  endfunction

  function automatic out_item_t console_apply(in_item_t cmd);
    out_item_t rep;
    rep = '0;
    case (cmd.mode)
      MODE_PRINT: begin
        if (cmd.char_code == CH_NEWLINE) begin
          if (cursor_line + 1 < LINES) cursor_at = (cursor_line + 1) * COLS;
          else scroll_screen();
        end else if (cmd.char_code == CH_BACKSPACE) begin
          if (cursor_at > 0) cursor_at--;
          screen_cells[cursor_at] = cell_of(CH_SPACE);
        end else begin
          screen_cells[cursor_at] = cell_of(cmd.char_code);
          cursor_at++;
          if (cursor_at >= CELLS) scroll_screen();
        end
        cursor_line = cursor_at / COLS;
      end
      MODE_READ: begin
        if (cmd.cell_addr < CELLS) rep.cell_word = screen_cells[cmd.cell_addr];
      end
      MODE_CLEAR: begin
        blank_screen(cell_of(CH_BLANK));
        cursor_at = 0;
        cursor_line = 0;
      end
      default: ;
    endcase
    rep.cursor_pos = 11'(cursor_at);
    rep.cursor_row = 5'(cursor_line);
    return rep;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_reports.push_back(console_apply(in_data));
      if (!in_valid || in_ready) begin
        if (command_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= command_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected transfer %h", $time, out_data);
          mismatch_count++;
        end else begin
          want = expected_reports.pop_front();
          if (out_data.cell_word !== want.cell_word) begin
            $display("%0t: cell_word expected %h actual %h", $time, want.cell_word,
                     out_data.cell_word);
            mismatch_count++;
          end
          if (out_data.cursor_pos !== want.cursor_pos) begin
            $display("%0t: cursor_pos expected %0d actual %0d", $time, want.cursor_pos,
                     out_data.cursor_pos);
            mismatch_count++;
          end
          if (out_data.cursor_row !== want.cursor_row) begin
            $display("%0t: cursor_row expected %0d actual %0d", $time, want.cursor_row,
                     out_data.cursor_row);
            mismatch_count++;
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("text_console_writer_top_tb: FAIL");
    $finish;
  end

  task automatic queue_cmd(logic [1:0] m, logic [7:0] c, logic [10:0] a);
    in_item_t cmd;
    cmd.mode = m;
    cmd.char_code = c;
    cmd.cell_addr = a;
    command_backlog.push_back(cmd);
  endtask

  task automatic queue_session(int unsigned target);
    int unsigned pushed;
    int unsigned sel;
    int unsigned run;
    pushed = 0;
    while (pushed < target) begin
      sel = $urandom_range(0, 199);
      if (sel == 0) begin
        queue_cmd(MODE_CLEAR, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
        pushed++;
      end else if (sel < 4) begin
        queue_cmd(MODE_IDLE, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
        pushed++;
      end else if (sel < 30) begin
        queue_cmd(MODE_READ, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
        pushed++;
      end else if (sel < 40) begin
        run = $urandom_range(1, 3);
        repeat (run) queue_cmd(MODE_PRINT, CH_BACKSPACE, 11'($urandom_range(0, 2047)));
        pushed += run;
      end else if (sel < 52) begin
        queue_cmd(MODE_PRINT, CH_NEWLINE, 11'($urandom_range(0, 2047)));
        pushed++;
      end else begin
        run = ($urandom_range(0, 14) == 0) ? $urandom_range(60, 100) : $urandom_range(1, 12);
        repeat (run)
          queue_cmd(MODE_PRINT, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
        pushed += run;
      end
    end
  endtask

  task automatic wait_drained();
    while (command_backlog.size() != 0 || in_valid || expected_reports.size() != 0)
      @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned send_pct[4];
    int unsigned recv_pct[4];
    logic [7:0] attr_plan[4];
    send_pct = '{0, 82, 0, 8};
    recv_pct = '{0, 0, 82, 8};
    attr_plan = '{8'hFF, 8'h00, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
    text_attr = ATTR_RESET;
    cursor_at = 0;
    cursor_line = 0;
    blank_screen({ATTR_RESET, CH_BLANK});
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    queue_cmd(MODE_READ, CH_BLANK, 11'd0);
    queue_cmd(MODE_READ, CH_BLANK, 11'(CELLS - 1));
    queue_cmd(MODE_READ, CH_BLANK, 11'(CELLS));
    queue_cmd(MODE_READ, 8'hFF, 11'h7FF);
    queue_cmd(MODE_IDLE, 8'hFF, 11'h7FF);
    queue_cmd(MODE_PRINT, CH_BACKSPACE, 11'd0);
    queue_cmd(MODE_READ, CH_BLANK, 11'd0);
    queue_cmd(MODE_PRINT, 8'hFF, 11'd0);
    queue_cmd(MODE_PRINT, CH_BLANK, 11'd0);
    queue_cmd(MODE_PRINT, CH_LETTER, 11'h7FF);
    queue_cmd(MODE_PRINT, CH_BACKSPACE, 11'd0);
    queue_cmd(MODE_READ, CH_BLANK, 11'd2);
    queue_cmd(MODE_READ, CH_BLANK, 11'd1);
    queue_cmd(MODE_PRINT, CH_NEWLINE, 11'd0);
    queue_cmd(MODE_PRINT, 8'h55, 11'd0);
    queue_cmd(MODE_PRINT, 8'hAA, 11'd0);
    queue_cmd(MODE_READ, CH_BLANK, 11'(COLS));
    queue_cmd(MODE_READ, CH_BLANK, 11'(COLS + 1));
    queue_cmd(MODE_CLEAR, 8'hFF, 11'h7FF);
    queue_cmd(MODE_READ, CH_BLANK, 11'(COLS));
    queue_cmd(MODE_PRINT, 8'h7E, 11'h7FF);
    queue_cmd(MODE_READ, CH_BLANK, 11'd0);

    for (int p = 0; p < 4; p++) begin
      wait_drained();
      cfg_we <= 1'b1;
      cfg_wdata <= attr_plan[p];
      text_attr = attr_plan[p];
      @(posedge clk);
      cfg_we <= 1'b0;
      send_idle_pct = send_pct[p];
      recv_stall_pct = recv_pct[p];
      queue_session(SESSION_ITEMS);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("text_console_writer_top_tb: PASS");
    end else begin
      $display("text_console_writer_top_tb: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: files.f
rtl/core/tcw_pkg.sv
rtl/core/tcw_front.sv
rtl/core/tcw_queue.sv
rtl/core/tcw_back.sv
rtl/core/text_console_writer_top.sv
tb/text_console_writer_top_tb.sv
